FILE: rtl/edsch_pkg.sv
// Shared types and constants for the event deadline scheduler.
// No dependencies; the scheduler, cell and chain files import this package.
package edsch_pkg;

	localparam int EVENT_SOURCES = 16;
	localparam int FIRED_W       = 16;
	localparam int PAD_W         = (EVENT_SOURCES > FIRED_W) ? EVENT_SOURCES : FIRED_W;

	localparam logic [30:0] MAX_SLICE_RST = 31'd33868800;
	localparam logic [31:0] EN_BITS       = 32'h0000_0401;

	typedef enum logic [1:0] {
		OP_ARM     = 2'd0,
		OP_SERVICE = 2'd1,
		OP_RESCHED = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_HOLD
	} state_t;

	// Token and running minimum handed from cell to cell.
	typedef struct packed {
		logic        tok;
		logic [31:0] best;
	} chain_t;

	// Broadcast to every cell for the walk in progress.
	typedef struct packed {
		logic        service;
		logic [31:0] now;
	} walk_ctl_t;

	// Deadline write into one cell.
	typedef struct packed {
		logic        we;
		logic [31:0] deadline;
	} arm_t;

endpackage

FILE: rtl/edsch_if.sv
// Valid/ready channel interfaces for scheduler items and results.
// Uses no package; field widths are fixed.
interface edsch_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [3:0]  event_index;
	logic [31:0] deadline;
	logic [31:0] now;
	logic [31:0] irq_status;
	logic [31:0] irq_mask;
	logic [31:0] cop0_status;

	modport source(output valid, op, event_index, deadline, now, irq_status, irq_mask,
		cop0_status, input ready);
	modport sink(input valid, op, event_index, deadline, now, irq_status, irq_mask,
		cop0_status, output ready);
endinterface

interface edsch_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] fired_mask;
	logic [31:0] next_deadline;
	logic        take_exception;

	modport source(output valid, fired_mask, next_deadline, take_exception, input ready);
	modport sink(input valid, fired_mask, next_deadline, take_exception, output ready);
endinterface

FILE: rtl/event_deadline_scheduler.sv
// Arm item: the deadline is written at accept; the result then moves to the output register.
// Service and reschedule items: the token walks the cell row, one cell a cycle,
// and the result is registered when the token leaves the last cell. No item is
// taken until the last item's result has moved into the output register.
// The output register lets the next item in while a result waits to be taken.
// arst_n clears pending bits, next service cycle, handshake state; max_slice resets.
module event_deadline_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	edsch_req_if.sink   req,
	edsch_rsp_if.source rsp,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata
);
	import edsch_pkg::*;

	state_t      state_q, state_nxt;
	logic [30:0] max_slice_q;
	logic [31:0] next_svc_q;
	logic        start_q;
	walk_ctl_t   ctl_q;
	logic        exc_q;

	logic [15:0] res_fired_q;
	logic [31:0] res_next_q;
	logic        res_exc_q;

	logic        out_vld_q;
	logic [15:0] out_fired_q;
	logic [31:0] out_next_q;
	logic        out_exc_q;

	logic        accept;
	logic        is_walk;
	logic        is_arm;
	logic        walk_done;
	logic        load_out;
	logic        in_ready;
	chain_t      head;
	chain_t      tail;
	logic [EVENT_SOURCES-1:0] fired_vec;
	logic [PAD_W-1:0]         fired_pad;
	logic [31:0]              walk_next;

	always_comb begin
		is_walk = 1'b0;
		is_arm  = 1'b0;
		unique case (op_t'(req.op))
			OP_ARM:     is_arm  = 1'b1;
			OP_SERVICE: is_walk = 1'b1;
			OP_RESCHED: is_walk = 1'b1;
			default:    ;
		endcase
	end

	assign accept    = req.valid && in_ready;
	assign walk_done = (state_q == S_WALK) && tail.tok;
	assign fired_pad = PAD_W'(fired_vec);
	assign walk_next = ctl_q.now + tail.best;

	assign head = '{tok: start_q, best: {1'b0, max_slice_q}};

	edsch_chain u_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.arm_we       (accept && is_arm),
		.arm_index    (req.event_index),
		.arm_deadline (req.deadline),
		.ctl          (ctl_q),
		.head         (head),
		.tail         (tail),
		.fired        (fired_vec)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = is_walk ? S_WALK : S_HOLD;
				end
			end
			S_WALK: begin
				if (walk_done) begin
					state_nxt = S_HOLD;
				end
			end
			S_HOLD: begin
				if (load_out) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_WALK:  ;
			S_HOLD:  load_out = !out_vld_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_slice_q <= MAX_SLICE_RST;
			next_svc_q  <= 32'd0;
			start_q     <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= accept && is_walk;
			if (cfg_we) begin
				max_slice_q <= cfg_wdata;
			end
			if (walk_done) begin
				next_svc_q <= walk_next;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q.now     <= req.now;
			ctl_q.service <= (op_t'(req.op) == OP_SERVICE);
			exc_q         <= (op_t'(req.op) == OP_SERVICE)
				&& ((req.irq_status & req.irq_mask) != 32'd0)
				&& ((req.cop0_status & EN_BITS) == EN_BITS);
			// arm and undefined op: nothing fires, hold the last service cycle
			res_fired_q   <= 16'd0;
			res_next_q    <= next_svc_q;
			res_exc_q     <= 1'b0;
		end else if (walk_done) begin
			res_fired_q <= ctl_q.service ? fired_pad[FIRED_W-1:0] : 16'd0;
			res_next_q  <= walk_next;
			res_exc_q   <= exc_q;
		end
		if (load_out) begin
			out_fired_q <= res_fired_q;
			out_next_q  <= res_next_q;
			out_exc_q   <= res_exc_q;
		end
	end

	assign req.ready          = in_ready;
	assign rsp.valid          = out_vld_q;
	assign rsp.fired_mask     = out_fired_q;
	assign rsp.next_deadline  = out_next_q;
	assign rsp.take_exception = out_exc_q;

endmodule

FILE: rtl/edsch_cell.sv
// One event source: pending bit, deadline, and one step of the expiry walk.
// Depends on edsch_pkg.
module edsch_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  edsch_pkg::arm_t      arm,
	input  edsch_pkg::walk_ctl_t ctl,
	input  edsch_pkg::chain_t    chain_in,
	output edsch_pkg::chain_t    chain_out,
	output logic                 fired
);
	import edsch_pkg::*;

	logic        pend_q;
	logic [31:0] dl_q;
	logic        fired_q;
	logic        tok_q;
	logic [31:0] best_q;

	logic [31:0] age;
	logic [31:0] ahead;
	logic        expire;
	logic        closer;

	assign age    = ctl.now - dl_q;
	assign ahead  = dl_q - ctl.now;
	// signed (now - deadline) >= 0
	assign expire = ctl.service && pend_q && !age[31];
	// strictly positive signed distance below the running minimum
	assign closer = pend_q && (ahead != 32'd0) && !ahead[31] && (ahead < chain_in.best);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= chain_in.tok;
			if (arm.we) begin
				pend_q <= 1'b1;
			end else if (chain_in.tok && expire) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (arm.we) begin
			dl_q <= arm.deadline;
		end
		if (chain_in.tok) begin
			fired_q <= expire;
			best_q  <= closer ? ahead : chain_in.best;
		end
	end

	assign chain_out = '{tok: tok_q, best: best_q};
	assign fired     = fired_q;

endmodule

FILE: rtl/edsch_chain.sv
// Row of EVENT_SOURCES cells; the walk token and minimum move one cell a cycle.
// Depends on edsch_pkg and edsch_cell.
module edsch_chain (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  arm_we,
	input  logic [3:0]                            arm_index,
	input  logic [31:0]                           arm_deadline,
	input  edsch_pkg::walk_ctl_t                  ctl,
	input  edsch_pkg::chain_t                     head,
	output edsch_pkg::chain_t                     tail,
	output logic [edsch_pkg::EVENT_SOURCES-1:0]   fired
);
	import edsch_pkg::*;

	chain_t link [EVENT_SOURCES+1];
	arm_t   arm  [EVENT_SOURCES];

	assign link[0] = head;
	assign tail    = link[EVENT_SOURCES];

	always_comb begin
		for (int i = 0; i < EVENT_SOURCES; i++) begin
			arm[i].we       = arm_we && (int'(arm_index) == i);
			arm[i].deadline = arm_deadline;
		end
	end

	for (genvar g = 0; g < EVENT_SOURCES; g++) begin : g_cell
		edsch_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.arm       (arm[g]),
			.ctl       (ctl),
			.chain_in  (link[g]),
			.chain_out (link[g+1]),
			.fired     (fired[g])
		);
	end

endmodule

FILE: rtl/edsch_checker.sv
// Port-level checks for event_deadline_scheduler, attached by bind.
// Depends on the top level's ports only.
module edsch_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_next_deadline
);
	logic [1:0] owed_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = req_valid && req_ready;
	assign out_acc = rsp_valid && rsp_ready;

	// count items whose results are still owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= 2'd0;
		end else begin
			owed_q <= owed_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_deadline))
		else $error("result dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !req_ready)
		else $error("item taken while previous item still in work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> owed_q != 2'd0)
		else $error("result delivered with no item owed");

	a_owed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> owed_q != 2'd2 && owed_q != 2'd3)
		else $error("item taken while two results owed");

endmodule

bind event_deadline_scheduler edsch_checker u_edsch_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_next_deadline (rsp.next_deadline)
);
